/* design/scbs_pkg.sv */
// Package for the strided copy and byte swap core: item structs, register
// indexes, error codes and value size codes. No dependencies.
package scbs_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ENCODE_MODE      = 3'd0,
    REG_SWAP_ENABLE      = 3'd1,
    REG_VALUE_BYTES      = 3'd2,
    REG_REPEAT_COUNT     = 3'd3,
    REG_SKIP_COUNT       = 3'd4,
    REG_VALUES_PER_GROUP = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_SIZE = 2'd1,
    ERR_END  = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    SZ_1 = 2'd0,
    SZ_2 = 2'd1,
    SZ_4 = 2'd2,
    SZ_8 = 2'd3
  } size_e;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_ELEMENT = 1'b1;

  typedef struct packed {
    logic        func;
    logic [2:0]  table_slot;
    logic [15:0] skip_bytes;
    logic [63:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value_out;
    logic [31:0] src_offset;
    logic [31:0] dst_offset;
    logic        last;
    logic [1:0]  error;
  } out_item_t;

endpackage

/* design/scbs_ram.sv */
// Generic single write port RAM with one registered read port.
// No dependencies.
module scbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/scbs_swap.sv */
// Value path of the copy core: clears bytes above the value size and
// optionally reverses the byte order. Depends on scbs_pkg.
module scbs_swap import scbs_pkg::*; (
  input  logic [63:0] value_i,
  input  size_e       size_i,
  input  logic        swap_i,
  output logic [63:0] value_o
);

  logic [63:0] masked;
  logic [63:0] reversed;

  always_comb begin
    masked   = '0;
    reversed = '0;
    case (size_i)
      SZ_1: begin
        masked   = {56'd0, value_i[7:0]};
        reversed = masked;
      end
      SZ_2: begin
        masked = {48'd0, value_i[15:0]};
        for (int i = 0; i < 2; i++) reversed[8*i +: 8] = value_i[8*(1-i) +: 8];
      end
      SZ_4: begin
        masked = {32'd0, value_i[31:0]};
        for (int i = 0; i < 4; i++) reversed[8*i +: 8] = value_i[8*(3-i) +: 8];
      end
      SZ_8: begin
        masked = value_i;
        for (int i = 0; i < 8; i++) reversed[8*i +: 8] = value_i[8*(7-i) +: 8];
      end
      default: begin
        masked   = '0;
        reversed = '0;
      end
    endcase
    value_o = swap_i ? reversed : masked;
  end

endmodule

/* design/strided_copy_byte_swap_core.sv */
// Strided scatter/gather copy core with optional byte swap: top level.
// A result item is registered in the output stage when its element item is accepted.
// Throughput: one item per cycle while the skid entry is empty; a skid entry takes one
// more item while a result waits, and the input resumes after the receiver takes that result.
// Reset: async, active low; value size one byte, group counter one, control state zero.
// Depends on scbs_pkg, scbs_ram and scbs_swap.
module strided_copy_byte_swap_core import scbs_pkg::*; #(
  parameter int MAX_SKIPS    = 8,
  parameter int OFFSET_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int GIDX_W = $clog2(MAX_SKIPS);
  localparam int GRP_W  = GIDX_W + 1;
  localparam int OW     = OFFSET_WIDTH;

  // Configuration registers.
  logic        encode_mode_q, encode_mode_d;
  logic        swap_enable_q, swap_enable_d;
  logic [7:0]  value_bytes_q, value_bytes_d;
  logic [15:0] repeat_count_q, repeat_count_d;
  logic [3:0]  skip_count_q, skip_count_d;
  logic [15:0] vpg_q, vpg_d;

  // Transfer state.
  logic [15:0]       rep_q, rep_d;
  logic [GIDX_W-1:0] grp_q, grp_d;
  logic [15:0]       vcnt_q, vcnt_d;
  logic [OW-1:0]     enc_pos_q, enc_pos_d;
  logic [OW-1:0]     plain_pos_q, plain_pos_d;
  logic              done_q, done_d;

  // Skip table: entry 0 is kept in its own register since it is needed at the
  // start of every repetition; all entries also live in the RAM, whose registered
  // read is addressed by the next group index. Valid bits stand in for the
  // all-zero reset of the RAM, and a write to the entry being fetched is
  // forwarded.
  logic [15:0]          skip0_q;
  logic [MAX_SKIPS-1:0] tbl_valid_q;
  logic                 rd_valid_q;
  logic                 fwd_hit_q;
  logic [15:0]          fwd_data_q;
  logic [15:0]          ram_rdata;
  logic [15:0]          skip_grp;

  logic              in_acc, cfg_acc, cfg_hit;
  logic              tbl_we;
  logic [GIDX_W-1:0] tbl_waddr;

  // Output stage: main register plus a skid entry.
  out_item_t out_q, skid_q;
  logic      out_valid_q, skid_valid_q;
  out_item_t res;
  logic      res_valid;

  // Element datapath signals.
  size_e         size_code;
  logic          size_bad;
  logic [GRP_W-1:0] groups;
  logic          empty;
  logic          first_of_rep, group_end, rep_end;
  logic [16:0]   vcnt_inc;
  logic [GRP_W-1:0] grp_inc;
  logic [15:0]   rep_inc;
  logic [OW-1:0] enc_at;
  logic [OW-1:0] vb_ext;
  logic [63:0]   value_sw;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = !skid_valid_q;
  assign in_acc      = in_valid_i && in_ready_o;

  // Configuration writes. An index beyond the register list changes nothing.
  always_comb begin
    encode_mode_d  = encode_mode_q;
    swap_enable_d  = swap_enable_q;
    value_bytes_d  = value_bytes_q;
    repeat_count_d = repeat_count_q;
    skip_count_d   = skip_count_q;
    vpg_d          = vpg_q;
    cfg_hit        = 1'b0;
    if (cfg_acc) begin
      cfg_hit = 1'b1;
      case (cfg_index_i)
        REG_ENCODE_MODE:      encode_mode_d  = cfg_data_i[0];
        REG_SWAP_ENABLE:      swap_enable_d  = cfg_data_i[0];
        REG_VALUE_BYTES:      value_bytes_d  = cfg_data_i[7:0];
        REG_REPEAT_COUNT:     repeat_count_d = cfg_data_i;
        REG_SKIP_COUNT:       skip_count_d   = cfg_data_i[3:0];
        REG_VALUES_PER_GROUP: vpg_d          = cfg_data_i;
        default:              cfg_hit        = 1'b0;
      endcase
    end
  end

  // Value size decode: only 1, 2, 4 and 8 bytes are supported.
  always_comb begin
    size_bad  = 1'b0;
    size_code = SZ_1;
    case (value_bytes_q)
      8'd1:    size_code = SZ_1;
      8'd2:    size_code = SZ_2;
      8'd4:    size_code = SZ_4;
      8'd8:    size_code = SZ_8;
      default: size_bad  = 1'b1;
    endcase
  end

  scbs_swap u_swap (
    .value_i (in_item_i.value_in),
    .size_i  (size_code),
    .swap_i  (swap_enable_q),
    .value_o (value_sw)
  );

  // A skip count above the table depth behaves as the table depth.
  always_comb begin
    if (32'(skip_count_q) > MAX_SKIPS) begin
      groups = GRP_W'(MAX_SKIPS);
    end else begin
      groups = GRP_W'(skip_count_q);
    end
  end

  assign empty = done_q || (repeat_count_q == 16'd0) || (groups < GRP_W'(2)) ||
                 (vpg_q == 16'd0);

  assign skip_grp = fwd_hit_q ? fwd_data_q : (rd_valid_q ? ram_rdata : 16'd0);

  assign vb_ext       = OW'(value_bytes_q);
  assign first_of_rep = (vcnt_q == 16'd0) && (grp_q == GIDX_W'(1));
  assign vcnt_inc     = {1'b0, vcnt_q} + 17'd1;
  assign group_end    = vcnt_inc >= {1'b0, vpg_q};
  assign grp_inc      = {1'b0, grp_q} + GRP_W'(1);
  assign rep_inc      = rep_q + 16'd1;
  assign rep_end      = grp_inc >= groups;
  assign enc_at       = enc_pos_q + (first_of_rep ? OW'(skip0_q) : OW'(0));

  // Element processing and counter update.
  always_comb begin
    rep_d       = rep_q;
    grp_d       = grp_q;
    vcnt_d      = vcnt_q;
    enc_pos_d   = enc_pos_q;
    plain_pos_d = plain_pos_q;
    done_d      = done_q;
    res         = '0;
    res_valid   = 1'b0;

    if (in_acc && (in_item_i.func == FUNC_ELEMENT)) begin
      res_valid = 1'b1;
      if (size_bad) begin
        res.error = ERR_SIZE;
      end else if (empty) begin
        res.error = ERR_END;
      end else begin
        // The encoded position takes the repetition's leading skip, the value
        // and, at the end of a group, that group's skip in one sum.
        enc_pos_d   = enc_pos_q + (first_of_rep ? OW'(skip0_q) : OW'(0)) + vb_ext +
                      (group_end ? OW'(skip_grp) : OW'(0));
        plain_pos_d = plain_pos_q + vb_ext;
        vcnt_d      = vcnt_inc[15:0];
        if (group_end) begin
          vcnt_d = 16'd0;
          grp_d  = grp_inc[GIDX_W-1:0];
          if (rep_end) begin
            grp_d = GIDX_W'(1);
            rep_d = rep_inc;
            if (rep_inc >= repeat_count_q) begin
              done_d = 1'b1;
            end
          end
        end
        res.value_out = value_sw;
        if (encode_mode_q) begin
          res.src_offset = 32'(plain_pos_q);
          res.dst_offset = 32'(enc_at);
        end else begin
          res.src_offset = 32'(enc_at);
          res.dst_offset = 32'(plain_pos_q);
        end
        res.last  = done_d;
        res.error = ERR_NONE;
      end
    end

    // Any register write restarts the transfer; the table is kept.
    if (cfg_hit) begin
      rep_d       = 16'd0;
      grp_d       = GIDX_W'(1);
      vcnt_d      = 16'd0;
      enc_pos_d   = '0;
      plain_pos_d = '0;
      done_d      = 1'b0;
    end
  end

  // Skip table writes from load items; the slot wraps at the table depth.
  assign tbl_we = in_acc && (in_item_i.func == FUNC_LOAD);

  always_comb begin
    tbl_waddr = '0;
    for (int s = 0; s < 8; s++) begin
      if (in_item_i.table_slot == 3'(s)) begin
        tbl_waddr = GIDX_W'(s % MAX_SKIPS);
      end
    end
  end

  scbs_ram #(
    .WIDTH (16),
    .DEPTH (MAX_SKIPS)
  ) u_skip_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (in_item_i.skip_bytes),
    .raddr_i (grp_d),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      encode_mode_q  <= 1'b0;
      swap_enable_q  <= 1'b0;
      value_bytes_q  <= 8'd1;
      repeat_count_q <= 16'd0;
      skip_count_q   <= 4'd0;
      vpg_q          <= 16'd0;
      rep_q          <= 16'd0;
      grp_q          <= GIDX_W'(1);
      vcnt_q         <= 16'd0;
      enc_pos_q      <= '0;
      plain_pos_q    <= '0;
      done_q         <= 1'b0;
      skip0_q        <= 16'd0;
      tbl_valid_q    <= '0;
      rd_valid_q     <= 1'b0;
      fwd_hit_q      <= 1'b0;
    end else begin
      encode_mode_q  <= encode_mode_d;
      swap_enable_q  <= swap_enable_d;
      value_bytes_q  <= value_bytes_d;
      repeat_count_q <= repeat_count_d;
      skip_count_q   <= skip_count_d;
      vpg_q          <= vpg_d;
      rep_q          <= rep_d;
      grp_q          <= grp_d;
      vcnt_q         <= vcnt_d;
      enc_pos_q      <= enc_pos_d;
      plain_pos_q    <= plain_pos_d;
      done_q         <= done_d;
      if (tbl_we) begin
        tbl_valid_q[tbl_waddr] <= 1'b1;
        if (tbl_waddr == GIDX_W'(0)) begin
          skip0_q <= in_item_i.skip_bytes;
        end
      end
      rd_valid_q <= tbl_valid_q[grp_d];
      fwd_hit_q  <= tbl_we && (tbl_waddr == grp_d);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= in_item_i.skip_bytes;
  end

  // Output stage. While the main register is stalled a new result goes to the
  // skid entry, and input acceptance stops only when the skid entry is full.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_ready_i) begin
        if (res_valid) begin
          skid_valid_q <= 1'b1;
        end
      end else if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && !out_ready_i) begin
      if (res_valid) begin
        skid_q <= res;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
